// ----- design/xtea_pkg.sv -----
// shared types, constants and schedule functions for the xtea cipher pipeline
`default_nettype none

package xtea_pkg;

	localparam int unsigned WORD_W     = 32;
	localparam int unsigned HALF_STEPS = 64;
	localparam int unsigned IN_TDATA_W = 64;
	localparam int unsigned OUT_TDATA_W = 64;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [WORD_W-1:0] DELTA = 32'h9E37_79B9;

	// key register indexes on the config port
	localparam logic [CFG_IDX_W-1:0] KEY_WORD0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] KEY_WORD3 = 3'd3;

	// direction codes carried in the mode bit
	localparam logic MODE_ENC = 1'b0;
	localparam logic MODE_DEC = 1'b1;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  mode;
		word_t v0;
		word_t v1;
	} blk_t;

	// per-stage round keys, sum already folded in
	typedef struct packed {
		logic  even;
		word_t enc_sk;
		word_t dec_sk;
	} stage_key_t;

	function automatic word_t round_sum(input int unsigned n);
		logic [63:0] p;
		p = 64'(n) * 64'(DELTA);
		return p[WORD_W-1:0];
	endfunction

	// encrypt: even half step uses sum of round r, odd one uses sum of round r+1
	function automatic word_t enc_sum(input int unsigned j);
		return ((j % 2) == 0) ? round_sum(j / 2) : round_sum(j / 2 + 1);
	endfunction

	function automatic logic [1:0] enc_key_idx(input int unsigned j);
		word_t s;
		s = enc_sum(j);
		return ((j % 2) == 0) ? s[1:0] : s[12:11];
	endfunction

	// decrypt: sum counts down from delta*32
	function automatic word_t dec_sum(input int unsigned j);
		return ((j % 2) == 0) ? round_sum(32 - j / 2) : round_sum(31 - j / 2);
	endfunction

	function automatic logic [1:0] dec_key_idx(input int unsigned j);
		word_t s;
		s = dec_sum(j);
		return ((j % 2) == 0) ? s[12:11] : s[1:0];
	endfunction

endpackage

`default_nettype wire

// ----- design/xtea_half_round.sv -----
// one registered half round of xtea, direction picked per beat
`default_nettype none

module xtea_half_round (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               vld_in,
	input  wire xtea_pkg::blk_t     blk_in,
	input  wire xtea_pkg::stage_key_t key,
	output logic                    vld_s1,
	output xtea_pkg::blk_t          blk_s1
);

	logic            upd_v0;
	xtea_pkg::word_t x;
	xtea_pkg::word_t tgt;
	xtea_pkg::word_t sk;
	xtea_pkg::word_t mixv;
	xtea_pkg::word_t res;

	always_comb begin
		// encrypt touches v0 on even steps, decrypt on odd ones
		upd_v0 = key.even ^ (blk_in.mode == xtea_pkg::MODE_DEC);
		x      = upd_v0 ? blk_in.v1 : blk_in.v0;
		tgt    = upd_v0 ? blk_in.v0 : blk_in.v1;
		sk     = (blk_in.mode == xtea_pkg::MODE_DEC) ? key.dec_sk : key.enc_sk;
		mixv   = (((x << 4) ^ (x >> 5)) + x) ^ sk;
		res    = (blk_in.mode == xtea_pkg::MODE_DEC) ? (tgt - mixv) : (tgt + mixv);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_in) begin
			blk_s1.mode <= blk_in.mode;
			blk_s1.v0   <= upd_v0 ? res : blk_in.v0;
			blk_s1.v1   <= upd_v0 ? blk_in.v1 : res;
		end
	end

endmodule

`default_nettype wire

// ----- design/xtea_out_fifo.sv -----
// two-entry result buffer at the pipeline tail
`default_nettype none

module xtea_out_fifo (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	input  wire logic [xtea_pkg::OUT_TDATA_W-1:0]      push_data,
	output logic                                       room,
	output logic                                       out_valid,
	input  wire logic                                  out_ready,
	output logic [xtea_pkg::OUT_TDATA_W-1:0]           out_data
);

	logic [xtea_pkg::OUT_TDATA_W-1:0] mem_q [2];
	logic                             wr_ptr_q;
	logic                             rd_ptr_q;
	logic [1:0]                       cnt_q;
	logic                             pop;

	assign room      = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ----- design/xtea_block_cipher_unit.sv -----
// top level: fully unrolled xtea pipeline with key registers and result buffer
//
//  channel  dir  width  beat contents (low bit up)
//  s_*      in   1+64   tuser: mode; tdata: block_low, block_high
//  m_*      out  64     out_low, out_high
//  cfg_*    in   3+32   key word index, key word value
//
// one beat can enter every cycle while the buffer has room; each of the 64
// half rounds is its own register stage, so a block passes through every
// half round register and then the result buffer. the stage enable comes
// from the buffer's registered count: when the buffer holds two results the
// whole pipeline freezes and s_tready drops, nothing is lost or repeated.
// reset clears the valid bits, the buffer pointers and the key words to zero.
`default_nettype none

module xtea_block_cipher_unit (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// slave side
	input  wire logic                                  s_tvalid,
	output logic                                       s_tready,
	input  wire logic                                  s_tuser,  // mode
	input  wire logic [xtea_pkg::IN_TDATA_W-1:0]       s_tdata,  // block_low, block_high
	// master side
	output logic                                       m_tvalid,
	input  wire logic                                  m_tready,
	output logic [xtea_pkg::OUT_TDATA_W-1:0]           m_tdata,  // out_low, out_high
	// key config
	input  wire logic                                  cfg_we,
	input  wire logic [xtea_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [xtea_pkg::WORD_W-1:0]           cfg_data
);

	localparam int unsigned N = xtea_pkg::HALF_STEPS;

	// key words; the user writes them only while the pipe is empty, the block does not enforce it
	xtea_pkg::word_t key_q [4];

	// stage chain: index 0 is the input beat, index N the last half round
	logic           vld [N+1];
	xtea_pkg::blk_t blk [N+1];
	logic           en;
	logic           room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 4; i++) begin
				key_q[i] <= '0;
			end
		end else if (cfg_we) begin
			case (cfg_index)
				xtea_pkg::KEY_WORD0: key_q[0] <= cfg_data;
				xtea_pkg::KEY_WORD1: key_q[1] <= cfg_data;
				xtea_pkg::KEY_WORD2: key_q[2] <= cfg_data;
				xtea_pkg::KEY_WORD3: key_q[3] <= cfg_data;
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// whole pipe moves together whenever the result buffer has a free slot
	assign en       = room;
	assign s_tready = en;

	// unpack the input beat
	assign vld[0]      = s_tvalid;
	assign blk[0].mode = s_tuser;
	assign blk[0].v0   = s_tdata[31:0];
	assign blk[0].v1   = s_tdata[63:32];

	for (genvar j = 0; j < N; j++) begin : g_stage
		localparam xtea_pkg::word_t ENC_S   = xtea_pkg::enc_sum(j);
		localparam xtea_pkg::word_t DEC_S   = xtea_pkg::dec_sum(j);
		localparam logic [1:0]      ENC_IDX = xtea_pkg::enc_key_idx(j);
		localparam logic [1:0]      DEC_IDX = xtea_pkg::dec_key_idx(j);

		xtea_pkg::stage_key_t sk;

		// round sum plus scheduled key word; the user keeps the key static while data flows, not enforced here
		assign sk.even   = ((j % 2) == 0);
		assign sk.enc_sk = ENC_S + key_q[ENC_IDX];
		assign sk.dec_sk = DEC_S + key_q[DEC_IDX];

		xtea_half_round u_half (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.vld_in (vld[j]),
			.blk_in (blk[j]),
			.key    (sk),
			.vld_s1 (vld[j+1]),
			.blk_s1 (blk[j+1])
		);
	end

	// result buffer decouples the pipe from a stalled consumer
	xtea_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (en && vld[N]),
		.push_data ({blk[N].v1, blk[N].v0}),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire
